@@ sv/bds_pkg.sv @@
package bds_pkg;

	typedef enum logic [2:0] {
		REG_MODE         = 3'd0,
		REG_FRAME_WIDTH  = 3'd1,
		REG_FRAME_HEIGHT = 3'd2,
		REG_GREEN_PHASE  = 3'd3,
		REG_RED_PHASE_X  = 3'd4,
		REG_RED_PHASE_Y  = 3'd5,
		REG_BLUE_PHASE_X = 3'd6,
		REG_BLUE_PHASE_Y = 3'd7
	} reg_idx_t;

	localparam logic [1:0] MODE_BILINEAR = 2'd0;
	localparam logic [1:0] MODE_EDGE     = 2'd1;
	localparam logic [1:0] MODE_CD       = 2'd2;
	localparam logic [1:0] MODE_RSVD     = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic        green_phase;
		logic        red_phase_x;
		logic        red_phase_y;
		logic        blue_phase_x;
		logic        blue_phase_y;
	} cfg_t;

endpackage

@@ sv/bds_line_store.sv @@
// Four raw lines in four row banks; reads all banks at the incoming pixel's column, writes the incoming pixel.
module bds_line_store #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [$clog2(4*MAX_WIDTH)-1:0]       wr_addr,
	input  logic [PIXEL_BITS-1:0]                wr_data,
	input  logic                                 rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]         rd_col,
	output logic [3:0][PIXEL_BITS-1:0]           rd_data
);
	localparam int AW = $clog2(4*MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH);

	// banked by row so all four rows are read out together
	logic [PIXEL_BITS-1:0] mem0 [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] mem1 [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] mem2 [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] mem3 [MAX_WIDTH];

	logic [1:0]    wr_bank;
	logic [CW-1:0] wr_col;
	assign wr_bank = wr_addr[AW-1:CW];
	assign wr_col  = wr_addr[CW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && wr_bank == 2'd0) mem0[wr_col] <= wr_data;
		if (wr_en && wr_bank == 2'd1) mem1[wr_col] <= wr_data;
		if (wr_en && wr_bank == 2'd2) mem2[wr_col] <= wr_data;
		if (wr_en && wr_bank == 2'd3) mem3[wr_col] <= wr_data;
		if (rd_en) begin
			rd_data[0] <= mem0[rd_col];
			rd_data[1] <= mem1[rd_col];
			rd_data[2] <= mem2[rd_col];
			rd_data[3] <= mem3[rd_col];
		end
	end
endmodule

@@ sv/bds_interp.sv @@
// Interpolation on a registered 5x5 window: two register stages.
module bds_interp #(
	parameter int PIXEL_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [24:0][PIXEL_BITS-1:0]            win,
	input  logic [1:0]                             mode,
	input  logic                                   g_odd,   // centre x+y+phase odd
	input  logic                                   ra,
	input  logic                                   rb,
	input  logic                                   ba,
	input  logic                                   bb,
	input  logic                                   g_border,
	input  logic                                   rb_border,
	input  logic                                   last,
	output logic [PIXEL_BITS-1:0]                  red_o,
	output logic [PIXEL_BITS-1:0]                  green_o,
	output logic [PIXEL_BITS-1:0]                  blue_o,
	output logic                                   last_o
);
	import bds_pkg::*;
	localparam int PB = PIXEL_BITS;
	localparam int SW = PB + 4;
	localparam logic signed [SW-1:0] PMAX = SW'((1 << PB) - 1);

	function automatic logic signed [SW-1:0] px(input logic [PB-1:0] v);
		return SW'(signed'({1'b0, v}));
	endfunction

	function automatic logic signed [SW-1:0] absd(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		logic signed [SW-1:0] d;
		d = a - b;
		return d < 0 ? -d : d;
	endfunction

	// green at cell (r,c); odd = site is green
	function automatic logic signed [SW-1:0] gat(input logic [24:0][PB-1:0] w,
			input int r, input int c, input logic odd, input logic [1:0] m);
		logic signed [SW-1:0] l, rt, u, d;
		l  = px(w[r*5+c-1]);
		rt = px(w[r*5+c+1]);
		u  = px(w[(r-1)*5+c]);
		d  = px(w[(r+1)*5+c]);
		if (odd) return px(w[r*5+c]);
		if (m == MODE_BILINEAR) return (l + rt + u + d) >>> 2;
		if (absd(l, rt) <= absd(u, d)) return (l + rt) >>> 1;
		return (u + d) >>> 1;
	endfunction

	function automatic logic [PB-1:0] clampv(input logic signed [SW-1:0] v);
		if (v < 0) return '0;
		if (v > PMAX) return PB'(PMAX);
		return PB'(v);
	endfunction

	// stage 1: greens at the centre and the eight neighbours used by colour difference
	logic signed [SW-1:0] gc_s1, g21_s1, g23_s1, g12_s1, g32_s1;
	logic signed [SW-1:0] g11_s1, g13_s1, g31_s1, g33_s1;
	logic [24:0][PB-1:0]  w_s1;
	logic [1:0]           m_s1;
	logic                 ra_s1, rb_s1, ba_s1, bb_s1, gb_s1, rbb_s1, last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			gc_s1  <= gat(win, 2, 2, g_odd, mode);
			g21_s1 <= gat(win, 2, 1, ~g_odd, mode);
			g23_s1 <= gat(win, 2, 3, ~g_odd, mode);
			g12_s1 <= gat(win, 1, 2, ~g_odd, mode);
			g32_s1 <= gat(win, 3, 2, ~g_odd, mode);
			g11_s1 <= gat(win, 1, 1, g_odd, mode);
			g13_s1 <= gat(win, 1, 3, g_odd, mode);
			g31_s1 <= gat(win, 3, 1, g_odd, mode);
			g33_s1 <= gat(win, 3, 3, g_odd, mode);
			w_s1   <= win;
			m_s1   <= mode;
			ra_s1  <= ra;
			rb_s1  <= rb;
			ba_s1  <= ba;
			bb_s1  <= bb;
			gb_s1  <= g_border;
			rbb_s1 <= rb_border;
			last_s1 <= last;
		end
	end

	function automatic logic [PB-1:0] plane(input logic a, input logic b,
			input logic cd, input logic [24:0][PB-1:0] w,
			input logic signed [SW-1:0] gc, input logic signed [SW-1:0] g21,
			input logic signed [SW-1:0] g23, input logic signed [SW-1:0] g12,
			input logic signed [SW-1:0] g32, input logic signed [SW-1:0] g11,
			input logic signed [SW-1:0] g13, input logic signed [SW-1:0] g31,
			input logic signed [SW-1:0] g33);
		logic signed [SW-1:0] avg;
		if (a && b) return w[12];
		if (!a && b)
			avg = (px(w[11]) - (cd ? g21 : SW'(0)) + px(w[13]) - (cd ? g23 : SW'(0))) >>> 1;
		else if (a && !b)
			avg = (px(w[7]) - (cd ? g12 : SW'(0)) + px(w[17]) - (cd ? g32 : SW'(0))) >>> 1;
		else
			avg = (px(w[6]) - (cd ? g11 : SW'(0)) + px(w[8]) - (cd ? g13 : SW'(0))
				+ px(w[16]) - (cd ? g31 : SW'(0)) + px(w[18]) - (cd ? g33 : SW'(0))) >>> 2;
		if (cd) avg = avg + gc;
		return clampv(avg);
	endfunction

	logic cd_s1;
	assign cd_s1 = m_s1[1];

	always_ff @(posedge clk) begin
		if (en) begin
			green_o <= gb_s1 ? w_s1[12] : clampv(gc_s1);
			red_o   <= rbb_s1 ? w_s1[12] : plane(ra_s1, rb_s1, cd_s1, w_s1, gc_s1,
				g21_s1, g23_s1, g12_s1, g32_s1, g11_s1, g13_s1, g31_s1, g33_s1);
			blue_o  <= rbb_s1 ? w_s1[12] : plane(ba_s1, bb_s1, cd_s1, w_s1, gc_s1,
				g21_s1, g23_s1, g12_s1, g32_s1, g11_s1, g13_s1, g31_s1, g33_s1);
			last_o  <= last_s1;
		end
	end
endmodule

@@ sv/bayer_demosaic_stream_core.sv @@
// Streaming Bayer demosaic. Raw pixels arrive in tdata in raster order, with the drain
// flag in tuser, one beat per cycle; an RGB beat leaves for every input beat once
// 2*width+2 beats have gone in, and drain beats flush the frame tail. Four raw lines
// live in one banked synchronous RAM read at the incoming pixel's column; line-store
// read, window shift and two interpolation stages make four pipeline stages. All
// stages advance together on a single enable, so the core sustains one beat per clock
// whenever the output side takes results; an output stall holds the whole pipeline
// and the input with it. Line-store contents need no clearing pass: unwritten entries
// only reach borders.
module bayer_demosaic_stream_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int PIXEL_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // raw_value
	input  logic         s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // red_value, green_value, blue_value
	output logic         m_tlast,   // frame_end
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [10:0]  cfg_data
);
	import bds_pkg::*;
	localparam int PB = PIXEL_BITS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = $clog2(4*MAX_WIDTH);
	localparam int NW = 21;

	cfg_t cfg_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_CD, frame_width: 11'd1024, frame_height: 11'd1024,
				green_phase: 1'b1, red_phase_x: 1'b1, red_phase_y: 1'b1,
				blue_phase_x: 1'b0, blue_phase_y: 1'b0};
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:         cfg_q.mode <= cfg_data[1:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				REG_GREEN_PHASE:  cfg_q.green_phase <= cfg_data[0];
				REG_RED_PHASE_X:  cfg_q.red_phase_x <= cfg_data[0];
				REG_RED_PHASE_Y:  cfg_q.red_phase_y <= cfg_data[0];
				REG_BLUE_PHASE_X: cfg_q.blue_phase_x <= cfg_data[0];
				REG_BLUE_PHASE_Y: cfg_q.blue_phase_y <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective size
	logic [12:0] w_eff, h_eff;
	always_comb begin
		w_eff = 13'(cfg_q.frame_width);
		if (w_eff < 13'd5) w_eff = 13'd5;
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = 13'(cfg_q.frame_height);
		if (h_eff < 13'd5) h_eff = 13'd5;
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
	end
	logic [1:0] mode_eff;
	assign mode_eff = (cfg_q.mode == MODE_RSVD) ? MODE_CD : cfg_q.mode;

	// pipeline: s1 line-store read, s2 window, s3/s4 interpolation
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	assign en = ~v_s4 | m_tready;

	logic in_fire;
	logic cmd;
	assign cmd = s_tuser;
	assign s_tready = en;
	assign in_fire = s_tvalid & s_tready;

	// raster position of the incoming pixel, kept as column/row counters
	logic [NW-1:0] n_q;
	logic [12:0]   xi_q, yi_q;
	logic [12:0]   x_q, y_q;    // output position
	logic          drop;
	assign drop = cmd & (n_q == '0);
	logic take;
	assign take = in_fire & ~drop;

	logic [PB-1:0] val;
	assign val = cmd ? '0 : s_tdata[PB-1:0];

	logic emit;
	assign emit = n_q >= NW'({w_eff, 1'b0} + 14'd2);

	logic last_now;
	assign last_now = (y_q > h_eff - 13'd1) ||
		((y_q == h_eff - 13'd1) && (x_q >= w_eff - 13'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= '0;
			xi_q <= '0;
			yi_q <= '0;
			x_q  <= '0;
			y_q  <= '0;
		end else if (take) begin
			if (emit && last_now) begin
				n_q  <= '0;
				xi_q <= '0;
				yi_q <= '0;
				x_q  <= '0;
				y_q  <= '0;
			end else begin
				n_q <= n_q + 1'b1;
				if (xi_q >= w_eff - 13'd1) begin
					xi_q <= '0;
					yi_q <= yi_q + 1'b1;
				end else begin
					xi_q <= xi_q + 1'b1;
				end
				if (emit) begin
					if (x_q >= w_eff - 13'd1) begin
						x_q <= '0;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
			end
		end
	end

	// line store: read the column now, write the new pixel into its row bank.
	// The write to the same column in the same cycle lands after this read, so no hazard.
	logic [3:0][PB-1:0] ls_rd;
	bds_line_store #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PB)) u_ls (
		.clk     (clk),
		.wr_en   (take),
		.wr_addr (AW'({yi_q[1:0], xi_q[CW-1:0]})),
		.wr_data (val),
		.rd_en   (take),
		.rd_col  (xi_q[CW-1:0]),
		.rd_data (ls_rd)
	);

	// s1 side info
	logic [1:0]    yb_s1;
	logic [PB-1:0] val_s1;
	logic          emit_s1, last_s1;
	logic [12:0]   x_s1, y_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= take & emit;
	end
	logic hold_s1;   // window shifts only on accepted pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_s1 <= 1'b0;
		else if (en) hold_s1 <= take;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			yb_s1  <= yi_q[1:0];
			val_s1 <= val;
			emit_s1 <= emit;
			last_s1 <= last_now;
			x_s1   <= x_q;
			y_s1   <= y_q;
		end
	end

	// s2: 5x5 window shift
	logic [24:0][PB-1:0] win_q;
	logic [12:0] x_s2, y_s2;
	logic last_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			if (hold_s1) begin
				for (int r = 0; r < 5; r++)
					for (int c = 0; c < 4; c++)
						win_q[r*5+c] <= win_q[r*5+c+1];
				for (int r = 0; r < 4; r++)
					win_q[r*5+4] <= ls_rd[2'(yb_s1 + 2'(r))];
				win_q[24] <= val_s1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			last_s2 <= last_s1 & emit_s1;
		end
	end

	logic g_odd, gb, rbb;
	assign g_odd = x_s2[0] ^ y_s2[0] ^ cfg_q.green_phase;
	assign gb  = (x_s2 == '0) || (y_s2 == '0) || (x_s2 >= w_eff - 13'd1) ||
		(y_s2 >= h_eff - 13'd1);
	assign rbb = (x_s2 < 13'd2) || (y_s2 < 13'd2) || (x_s2 >= w_eff - 13'd2) ||
		(y_s2 >= h_eff - 13'd2);

	logic [PB-1:0] r_o, g_o, b_o;
	logic          l_o;
	bds_interp #(.PIXEL_BITS(PB)) u_interp (
		.clk       (clk),
		.en        (en),
		.win       (win_q),
		.mode      (mode_eff),
		.g_odd     (g_odd),
		.ra        (x_s2[0] ^ cfg_q.red_phase_x),
		.rb        (y_s2[0] ^ cfg_q.red_phase_y),
		.ba        (x_s2[0] ^ cfg_q.blue_phase_x),
		.bb        (y_s2[0] ^ cfg_q.blue_phase_y),
		.g_border  (gb),
		.rb_border (rbb),
		.last      (last_s2),
		.red_o     (r_o),
		.green_o   (g_o),
		.blue_o    (b_o),
		.last_o    (l_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {4'b0, 12'(b_o), 12'(g_o), 12'(r_o)};
	assign m_tlast  = l_o;

endmodule
